// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the converter, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define RHC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rhc assertion failed");

// Next-cycle implication.
`define RHC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rhc assertion failed");

`endif

// ===== sv/rhc_pkg.sv =====
// ----------------------------------------------------------------------------
// rhc_pkg
// Types and constants shared by the RGB to HSL converter modules.
// ----------------------------------------------------------------------------
package rhc_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int ALPHA_W      = 8;
  localparam int HUE_W        = 15;
  localparam int SAT_W        = 16;
  localparam int LIGHT_W      = 9;

  // Both divisions produce QUO_W quotient bits, one per cell.
  localparam int SAT_FRAC  = 16;
  localparam int QUO_W     = SAT_FRAC + 1;
  localparam int NUM_W     = CHANNEL_BITS + 3;
  localparam int HUE_SHIFT = 12;
  localparam int DIVD_W    = NUM_W + HUE_SHIFT;

  localparam int HUE_LIMIT = 23040;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
    logic [ALPHA_W-1:0]      alpha_in;
  } pix_in_t;

  typedef struct packed {
    logic [HUE_W-1:0]   hue;
    logic [SAT_W-1:0]   saturation;
    logic [LIGHT_W-1:0] lightness;
    logic [ALPHA_W-1:0] alpha_out;
  } pix_out_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] rem;
    logic [CHANNEL_BITS-1:0] dvs;
    logic [QUO_W-1:0]        low;
    logic [QUO_W-1:0]        quo;
  } div_lane_t;

  typedef struct packed {
    logic               vld;
    div_lane_t          hue;
    div_lane_t          sat;
    logic [LIGHT_W-1:0] lightness;
    logic [ALPHA_W-1:0] alpha;
  } cell_t;

endpackage

// ===== sv/rhc_prep.sv =====
// ----------------------------------------------------------------------------
// rhc_prep
// Finds the channel extremes and sets up the hue and saturation dividends
// and divisors for the divider cells.
// ----------------------------------------------------------------------------
module rhc_prep (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  rhc_pkg::pix_in_t in_data,
  input  logic            dn_load,
  output logic            load,
  output rhc_pkg::cell_t  prep_q
);

  localparam int CB = rhc_pkg::CHANNEL_BITS;

  rhc_pkg::cell_t prep_r;
  rhc_pkg::cell_t prep_nxt;

  logic [CB-1:0]                r_c, g_c, b_c, mx, mn, d, den;
  logic [CB:0]                  sum;
  logic                         grey;
  logic [rhc_pkg::NUM_W-1:0]    d_n, n;
  logic [rhc_pkg::DIVD_W-1:0]   hue_divd;

  assign load   = !prep_r.vld || dn_load;
  assign prep_q = prep_r;

  always_comb begin
    r_c = in_data.red;
    g_c = in_data.green;
    b_c = in_data.blue;
    mx  = (r_c > g_c) ? r_c : g_c;
    mx  = (mx > b_c) ? mx : b_c;
    mn  = (r_c < g_c) ? r_c : g_c;
    mn  = (mn < b_c) ? mn : b_c;
    d   = mx - mn;
    sum = {1'b0, mx} + {1'b0, mn};
    if (sum > {1'b0, {CB{1'b1}}}) begin
      den = CB'({{CB{1'b1}}, 1'b0} - sum);
    end else begin
      den = sum[CB-1:0];
    end
    grey = (d == '0);
    d_n  = rhc_pkg::NUM_W'(d);
    if (mx == r_c) begin
      if (g_c < b_c) begin
        n = (d_n << 2) + (d_n << 1) + rhc_pkg::NUM_W'(g_c) - rhc_pkg::NUM_W'(b_c);
      end else begin
        n = rhc_pkg::NUM_W'(g_c) - rhc_pkg::NUM_W'(b_c);
      end
    end else if (mx == g_c) begin
      n = (d_n << 1) + rhc_pkg::NUM_W'(b_c) - rhc_pkg::NUM_W'(r_c);
    end else begin
      n = (d_n << 2) + rhc_pkg::NUM_W'(r_c) - rhc_pkg::NUM_W'(g_c);
    end
    hue_divd = (rhc_pkg::DIVD_W'(n) << rhc_pkg::HUE_SHIFT) - (rhc_pkg::DIVD_W'(n) << 8);

    prep_nxt           = '0;
    prep_nxt.vld       = in_valid;
    prep_nxt.hue.rem   = CB'(hue_divd[rhc_pkg::DIVD_W-1:rhc_pkg::QUO_W]);
    prep_nxt.hue.low   = hue_divd[rhc_pkg::QUO_W-1:0];
    prep_nxt.hue.dvs   = grey ? CB'(1) : d;
    prep_nxt.hue.quo   = '0;
    prep_nxt.sat.rem   = d >> 1;
    prep_nxt.sat.low   = {d[0], {rhc_pkg::SAT_FRAC{1'b0}}};
    prep_nxt.sat.dvs   = grey ? CB'(1) : den;
    prep_nxt.sat.quo   = '0;
    prep_nxt.lightness = rhc_pkg::LIGHT_W'(sum);
    prep_nxt.alpha     = in_data.alpha_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_r.vld <= 1'b0;
    end else if (load) begin
      prep_r <= prep_nxt;
    end
  end

endmodule

// ===== sv/rhc_div_cell.sv =====
// ----------------------------------------------------------------------------
// rhc_div_cell
// One restoring-division step for both the hue and the saturation quotient,
// registered and handed to the next cell.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rhc_div_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  rhc_pkg::cell_t up,
  input  logic           dn_load,
  output logic           load,
  output rhc_pkg::cell_t cell_q
);

  localparam int CB = rhc_pkg::CHANNEL_BITS;
  localparam int QW = rhc_pkg::QUO_W;

  rhc_pkg::cell_t cell_r;
  rhc_pkg::cell_t cell_nxt;

  function automatic rhc_pkg::div_lane_t div_step(input rhc_pkg::div_lane_t l);
    logic [CB:0]        trial;
    logic [CB:0]        diff;
    rhc_pkg::div_lane_t res;
    trial   = {l.rem, l.low[QW-1]};
    diff    = trial - {1'b0, l.dvs};
    res     = l;
    res.low = {l.low[QW-2:0], 1'b0};
    if (trial >= {1'b0, l.dvs}) begin
      res.rem = diff[CB-1:0];
      res.quo = {l.quo[QW-2:0], 1'b1};
    end else begin
      res.rem = trial[CB-1:0];
      res.quo = {l.quo[QW-2:0], 1'b0};
    end
    return res;
  endfunction

  assign load   = !cell_r.vld || dn_load;
  assign cell_q = cell_r;

  always_comb begin
    cell_nxt     = up;
    cell_nxt.hue = div_step(up.hue);
    cell_nxt.sat = div_step(up.sat);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else if (load) begin
      cell_r <= cell_nxt;
    end
  end

  `RHC_ASSERT_IMPL(a_hue_rem_below_divisor, cell_r.vld, cell_r.hue.rem < cell_r.hue.dvs)
  `RHC_ASSERT_IMPL(a_sat_rem_below_divisor, cell_r.vld, cell_r.sat.rem < cell_r.sat.dvs)

endmodule

// ===== sv/rgb_to_hsl_converter_unit.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter_unit
// Converts 8-bit RGBA pixels to fixed-point hue, saturation and lightness.
// ----------------------------------------------------------------------------
// The unit takes one pixel word per clock and delivers one result word per
// clock when the output is not stalled: a prep register finds the channel
// extremes and sets up the dividends, a chain of 17 divider cells produces
// one bit of both the hue and the saturation quotient in each cell, and a
// final register clamps saturation and holds the result word. Every stage
// holds its word only while the stage after it is full and stalled, so gaps
// in the stream close up under back pressure.
`include "assert_macros.svh"

module rgb_to_hsl_converter_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rhc_pkg::pix_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rhc_pkg::pix_out_t out_data
);

  localparam int QW = rhc_pkg::QUO_W;

  rhc_pkg::cell_t    chain [0:QW];
  logic              ld    [0:QW];
  logic              prep_load;
  logic              out_vld_r;
  rhc_pkg::pix_out_t out_data_r;
  rhc_pkg::pix_out_t out_data_nxt;

  rhc_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .dn_load  (ld[0]),
    .load     (prep_load),
    .prep_q   (chain[0])
  );

  genvar gi;
  generate
    for (gi = 0; gi < QW; gi++) begin : g_cell
      rhc_div_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .up      (chain[gi]),
        .dn_load (ld[gi+1]),
        .load    (ld[gi]),
        .cell_q  (chain[gi+1])
      );
    end
  endgenerate

  assign ld[QW]   = !out_vld_r || !out_stall;
  assign in_stall = !prep_load;

  always_comb begin
    out_data_nxt.hue = chain[QW].hue.quo[rhc_pkg::HUE_W-1:0];
    if (chain[QW].sat.quo[QW-1]) begin
      out_data_nxt.saturation = '1;
    end else begin
      out_data_nxt.saturation = chain[QW].sat.quo[rhc_pkg::SAT_W-1:0];
    end
    out_data_nxt.lightness = chain[QW].lightness;
    out_data_nxt.alpha_out = chain[QW].alpha;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (ld[QW]) begin
      out_vld_r  <= chain[QW].vld;
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  `RHC_ASSERT_IMPL(a_stall_only_from_output, in_stall, out_vld_r && out_stall)
  `RHC_ASSERT_NEXT(a_accepted_word_in_prep, in_valid && !in_stall, chain[0].vld)
  `RHC_ASSERT_IMPL(a_hue_in_range, out_vld_r, out_data_r.hue < rhc_pkg::HUE_W'(rhc_pkg::HUE_LIMIT))
  `RHC_ASSERT_IMPL(a_sat_quotient_bound, chain[QW].vld, !(chain[QW].sat.quo[QW-1] && (|chain[QW].sat.quo[QW-2:0])))

endmodule

// ===== verif/rgb_to_hsl_converter_unit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter_unit_checker
// Watches the pixel and result channels of the converter. It computes the
// expected hue, saturation, lightness and opacity of every accepted pixel word
// and compares each accepted result word against the oldest one waiting.
// ----------------------------------------------------------------------------
module rgb_to_hsl_converter_unit_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  rhc_pkg::pix_in_t   in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  rhc_pkg::pix_out_t  out_data,
  output int unsigned        mismatches,
  output int unsigned        pending
);

  localparam longint FULL     = (longint'(1) << rhc_pkg::CHANNEL_BITS) - 1;
  localparam longint HUE_UNIT = 3840;
  localparam longint SAT_ONE  = 65536;
  localparam longint SAT_MAX  = 65535;

  rhc_pkg::pix_out_t hsl_expected[$];

  assign pending = hsl_expected.size();

  function automatic rhc_pkg::pix_out_t hsl_of_pixel(rhc_pkg::pix_in_t p);
    longint r, g, b, mx, mn, d, den, n, sat, hue;
    rhc_pkg::pix_out_t q;
    r = p.red;
    g = p.green;
    b = p.blue;
    mx = (r > g) ? r : g;
    mx = (mx > b) ? mx : b;
    mn = (r < g) ? r : g;
    mn = (mn < b) ? mn : b;
    sat = 0;
    hue = 0;
    if (mx != mn) begin
      d = mx - mn;
      den = (mx + mn > FULL) ? 2 * FULL - mx - mn : mx + mn;
      sat = (SAT_ONE * d) / den;
      if (sat > SAT_MAX) begin
        sat = SAT_MAX;
      end
      if (mx == r) begin
        n = (g < b) ? 6 * d + g - b : g - b;
      end else if (mx == g) begin
        n = 2 * d + b - r;
      end else begin
        n = 4 * d + r - g;
      end
      hue = (HUE_UNIT * n) / d;
    end
    q.hue        = rhc_pkg::HUE_W'(hue);
    q.saturation = rhc_pkg::SAT_W'(sat);
    q.lightness  = rhc_pkg::LIGHT_W'(mx + mn);
    q.alpha_out  = p.alpha_in;
    return q;
  endfunction

  function automatic bit field_ok(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    rhc_pkg::pix_out_t want;
    bit ok;
    if (!rst_n) begin
      hsl_expected.delete();
      mismatches <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        hsl_expected.push_back(hsl_of_pixel(in_data));
      end
      if (out_valid && !out_stall) begin
        if (hsl_expected.size() == 0) begin
          $error("result word arrived with no expectation pending: %p", out_data);
          mismatches <= mismatches + 1;
        end else begin
          want = hsl_expected.pop_front();
          ok = field_ok("hue", 32'(want.hue), 32'(out_data.hue))
             & field_ok("saturation", 32'(want.saturation), 32'(out_data.saturation))
             & field_ok("lightness", 32'(want.lightness), 32'(out_data.lightness))
             & field_ok("alpha_out", 32'(want.alpha_out), 32'(out_data.alpha_out));
          if (!ok) begin
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

endmodule

// ===== verif/rgb_to_hsl_converter_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter_unit_tb
// Drives the converter with directed corner pixels and then random pixel
// streams under four idling patterns, draining the pipeline between them,
// and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module rgb_to_hsl_converter_unit_tb;

  localparam int PHASE_WORDS = 160;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  rhc_pkg::pix_in_t  in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  rhc_pkg::pix_out_t out_data;
  int unsigned       mismatches;
  int unsigned       pending;
  int unsigned       send_gap_pct   = 0;
  int unsigned       recv_stall_pct = 0;

  rgb_to_hsl_converter_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  rgb_to_hsl_converter_unit_checker hsl_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic rhc_pkg::pix_in_t pixel(int r, int g, int b, int a);
    rhc_pkg::pix_in_t p;
    p.red      = rhc_pkg::CHANNEL_BITS'(r);
    p.green    = rhc_pkg::CHANNEL_BITS'(g);
    p.blue     = rhc_pkg::CHANNEL_BITS'(b);
    p.alpha_in = rhc_pkg::ALPHA_W'(a);
    return p;
  endfunction

  // Random pixels lean toward grey, tied channels and channels at the rails.
  function automatic rhc_pkg::pix_in_t random_pixel();
    rhc_pkg::pix_in_t p;
    p.red      = rhc_pkg::CHANNEL_BITS'($urandom);
    p.green    = rhc_pkg::CHANNEL_BITS'($urandom);
    p.blue     = rhc_pkg::CHANNEL_BITS'($urandom);
    p.alpha_in = rhc_pkg::ALPHA_W'($urandom);
    case ($urandom_range(7))
      0: begin
        p.green = p.red;
        p.blue  = p.red;
      end
      1: p.green = p.red;
      2: p.blue = p.red;
      3: p.blue = p.green;
      4: p.blue = '0;
      5: p.red = '1;
      default: ;
    endcase
    return p;
  endfunction

  task automatic send_pixel(input rhc_pkg::pix_in_t p);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  initial begin
    int unsigned gap_pct[4];
    int unsigned stall_pct[4];
    gap_pct   = '{0, 66, 0, 15};
    stall_pct = '{0, 0, 66, 15};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_pixel(pixel(0, 0, 0, 0));
    send_pixel(pixel(255, 255, 255, 255));
    send_pixel(pixel(255, 0, 0, 8'h80));
    send_pixel(pixel(0, 255, 0, 8'h01));
    send_pixel(pixel(0, 0, 255, 8'hFE));
    send_pixel(pixel(255, 255, 0, 8'h55));
    send_pixel(pixel(0, 255, 255, 8'hAA));
    send_pixel(pixel(255, 0, 255, 8'h00));
    send_pixel(pixel(255, 0, 1, 8'hFF));
    send_pixel(pixel(128, 128, 128, 8'h0F));
    send_pixel(pixel(255, 128, 128, 8'hF0));
    send_pixel(pixel(1, 0, 0, 8'h00));
    send_pixel(pixel(0, 1, 0, 8'h00));
    send_pixel(pixel(0, 0, 1, 8'h00));
    send_pixel(pixel(255, 254, 254, 8'h00));
    send_pixel(pixel(254, 255, 255, 8'h00));
    send_pixel(pixel(128, 0, 255, 8'h33));
    send_pixel(pixel(200, 100, 50, 8'hCC));
    send_pixel(pixel(50, 100, 200, 8'h3C));
    send_pixel(pixel(127, 128, 0, 8'hC3));
    send_pixel(pixel(128, 127, 255, 8'h99));
    send_pixel(pixel(255, 0, 128, 8'h01));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_gap_pct   = gap_pct[ph];
      recv_stall_pct = stall_pct[ph];
      repeat (PHASE_WORDS) send_pixel(random_pixel());
      drain();
    end

    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("rgb_to_hsl_converter_unit: match");
    end else begin
      $display("rgb_to_hsl_converter_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("rgb_to_hsl_converter_unit: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/rhc_pkg.sv
sv/rhc_prep.sv
sv/rhc_div_cell.sv
sv/rgb_to_hsl_converter_unit.sv
verif/rgb_to_hsl_converter_unit_checker.sv
verif/rgb_to_hsl_converter_unit_tb.sv
